// ===== hw/rtl/clr_pkg.sv =====
// Shared types and constants for the contribution list line resampler.
// Used by clr_mac and contribution_list_line_resampler_unit; depends on nothing.
`timescale 1ns / 1ps

package clr_pkg;

  // Hardware limits of the item fields: 12-bit indexes and 4-bit tap slots.
  localparam int unsigned IDX_SPAN  = 4096;
  localparam int unsigned SLOT_SPAN = 16;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned SRC_W    = 12;
  localparam int unsigned PROD_W   = SAMPLE_W + WEIGHT_W;
  localparam int unsigned FRAC_SH  = 14;

  typedef enum logic [1:0] {
    FUNC_LOAD_TAP     = 2'd0,
    FUNC_SET_COUNT    = 2'd1,
    FUNC_WRITE_SAMPLE = 2'd2,
    FUNC_COMPUTE      = 2'd3
  } func_e;

  typedef struct packed {
    func_e              func;
    logic [11:0]        dst_index;
    logic [3:0]         tap_slot;
    logic [11:0]        src_index;
    logic signed [15:0] weight;
    logic [4:0]         tap_count;
    logic signed [15:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [11:0]        pixel_index;
    logic signed [15:0] pixel_value;
    logic               saturated;
  } out_item_t;

  // Control from the sequencer to the multiply-accumulate datapath.
  typedef struct packed {
    logic acc_clear;
    logic mul_en;
    logic round_en;
  } mac_ctl_t;

endpackage

// ===== hw/rtl/clr_ram.sv =====
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Standalone; used for the line store and the tap and count tables.
`timescale 1ns / 1ps

module clr_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 16,
  parameter int unsigned AW    = 12
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/clr_mac.sv =====
// Multiply-accumulate datapath: registered product, wide accumulator,
// rounding with saturation, and the output clamp. Depends on clr_pkg.
`timescale 1ns / 1ps

module clr_mac #(
  parameter int unsigned ACC_W = 37
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  clr_pkg::mac_ctl_t   ctl_i,
  input  logic signed [15:0]  sample_i,
  input  logic signed [15:0]  weight_i,
  input  logic signed [15:0]  clamp_low_i,
  input  logic signed [15:0]  clamp_high_i,
  output logic                busy_o,
  output logic signed [15:0]  pixel_value_o,
  output logic                saturated_o
);

  localparam int unsigned SH_W = ACC_W + 1 - clr_pkg::FRAC_SH;
  localparam logic signed [ACC_W:0] RND_BIAS = (ACC_W+1)'(1 << (clr_pkg::FRAC_SH - 1));
  localparam logic signed [SH_W-1:0] SAT_MAX = SH_W'(32767);
  localparam logic signed [SH_W-1:0] SAT_MIN = -SH_W'(32768);

  logic signed [clr_pkg::PROD_W-1:0] prod_q;
  logic                              prod_vld_q;
  logic signed [ACC_W-1:0]           acc_q;
  logic signed [15:0]                val_q;
  logic                              sat_q;

  logic signed [ACC_W:0]  biased;
  logic signed [SH_W-1:0] shifted;
  logic signed [15:0]     val_d;
  logic                   sat_d;

  always_comb begin
    biased  = {acc_q[ACC_W-1], acc_q} + RND_BIAS;
    // Arithmetic shift right by the weight fraction: floor of the biased sum.
    shifted = biased[ACC_W:clr_pkg::FRAC_SH];
    val_d   = shifted[15:0];
    sat_d   = 1'b0;
    if (shifted > SAT_MAX) begin
      val_d = 16'sh7fff;
      sat_d = 1'b1;
    end else if (shifted < SAT_MIN) begin
      val_d = -16'sh8000;
      sat_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= ctl_i.mul_en;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= sample_i * weight_i;
    if (ctl_i.acc_clear) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    if (ctl_i.round_en) begin
      val_q <= val_d;
      sat_q <= sat_d;
    end
  end

  always_comb begin
    pixel_value_o = val_q;
    if (clamp_low_i < clamp_high_i) begin
      if (val_q < clamp_low_i) begin
        pixel_value_o = clamp_low_i;
      end else if (val_q > clamp_high_i) begin
        pixel_value_o = clamp_high_i;
      end
    end
  end

  assign saturated_o = sat_q;
  assign busy_o      = prod_vld_q;

endmodule

// ===== hw/rtl/contribution_list_line_resampler_unit.sv =====
// Top level of the contribution list line resampler: sequencer, register
// port, tap/count/line memories and output register. Uses clr_pkg, clr_ram, clr_mac.
//
//   Channel   Direction  Handshake                 Payload
//   in        input      in_valid_i / in_stall_o   clr_pkg::in_item_t
//   out       output     out_valid_o / out_stall_i clr_pkg::out_item_t
//   config    input      APB psel/penable/pready   clamp_low (0x0), clamp_high (0x4)
//
// Tap loads, tap count writes and sample writes do not stall the input.
// After its transfer a compute stalls the input until it is done: the tap count is read, then
// one tap table read is issued per cycle and then passes the line store read, the
// multiplier and the accumulator before the rounding and output register states.
// After reset the tap count table is cleared one entry a cycle (DST_MAX entries,
// at most 4096); no item is accepted until that pass is done.
// A result waiting on out_stall_i does not block loads; a following compute
// holds in its last cycle until the output register is free.
`timescale 1ns / 1ps

module contribution_list_line_resampler_unit #(
  parameter int unsigned LINE_MAX = 4096,
  parameter int unsigned DST_MAX  = 4096,
  parameter int unsigned MAX_TAPS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  clr_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output clr_pkg::out_item_t  out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned LINE_EFF = (LINE_MAX < clr_pkg::IDX_SPAN) ? LINE_MAX : clr_pkg::IDX_SPAN;
  localparam int unsigned DST_EFF  = (DST_MAX < clr_pkg::IDX_SPAN) ? DST_MAX : clr_pkg::IDX_SPAN;
  localparam int unsigned TAPS_EFF = (MAX_TAPS < clr_pkg::SLOT_SPAN) ? MAX_TAPS : clr_pkg::SLOT_SPAN;
  localparam int unsigned TAP_DEPTH = DST_EFF * TAPS_EFF;
  localparam int unsigned LINE_AW  = (LINE_EFF > 1) ? $clog2(LINE_EFF) : 1;
  localparam int unsigned DST_AW   = (DST_EFF > 1) ? $clog2(DST_EFF) : 1;
  localparam int unsigned TAP_AW   = (TAP_DEPTH > 1) ? $clog2(TAP_DEPTH) : 1;
  localparam int unsigned CNT_W    = $clog2(TAPS_EFF + 1);
  localparam int unsigned TAP_DW   = clr_pkg::SRC_W + clr_pkg::WEIGHT_W;
  localparam int unsigned ACC_W    = clr_pkg::PROD_W + CNT_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COUNT,
    ST_TAPS,
    ST_ROUND,
    ST_OUT
  } state_e;

  state_e state_q;

  logic [DST_AW-1:0]  clr_addr_q;
  logic [11:0]        dst_q;
  logic               dst_ok_q;
  logic [TAP_AW-1:0]  tap_addr_q;
  logic [CNT_W-1:0]   issue_left_q;
  logic               s1_q;
  logic               s2_q;
  logic signed [15:0] weight_q;
  logic               src_ok_q;
  logic signed [15:0] clamp_low_q;
  logic signed [15:0] clamp_high_q;
  logic               out_valid_q;
  clr_pkg::out_item_t out_data_q;

  logic               in_acc;
  logic               dst_ok_in;
  logic               slot_ok_in;
  logic               src_ok_in;
  logic [TAP_AW-1:0]  tap_base;
  logic [CNT_W-1:0]   cnt_sat;

  logic               tap_we;
  logic [TAP_AW-1:0]  tap_waddr;
  logic               tap_re;
  logic [TAP_DW-1:0]  tap_rdata;
  logic               cnt_we;
  logic [DST_AW-1:0]  cnt_waddr;
  logic [CNT_W-1:0]   cnt_wdata;
  logic               cnt_re;
  logic [CNT_W-1:0]   cnt_rdata;
  logic               line_we;
  logic               line_re;
  logic [LINE_AW-1:0] line_raddr;
  logic [15:0]        line_rdata;
  logic [clr_pkg::SRC_W-1:0] tap_src;

  clr_pkg::mac_ctl_t  mac_ctl;
  logic signed [15:0] mac_sample;
  logic               mac_busy;
  logic signed [15:0] mac_value;
  logic               mac_sat;
  logic               out_free;
  logic               cfg_wr;

  always_comb begin
    in_acc     = in_valid_i && (state_q == ST_IDLE);
    dst_ok_in  = {1'b0, in_data_i.dst_index} < 13'(DST_EFF);
    slot_ok_in = {1'b0, in_data_i.tap_slot} < 5'(TAPS_EFF);
    src_ok_in  = {1'b0, in_data_i.src_index} < 13'(LINE_EFF);
    tap_base   = TAP_AW'(TAP_AW'(in_data_i.dst_index[DST_AW-1:0]) * TAP_AW'(TAPS_EFF));
    cnt_sat    = (in_data_i.tap_count > 5'(TAPS_EFF)) ? CNT_W'(TAPS_EFF)
                                                        : CNT_W'(in_data_i.tap_count);

    tap_we    = in_acc && (in_data_i.func == clr_pkg::FUNC_LOAD_TAP) && dst_ok_in && slot_ok_in;
    tap_waddr = tap_base + TAP_AW'(in_data_i.tap_slot);
    tap_re    = (state_q == ST_TAPS) && (issue_left_q != '0);

    if (state_q == ST_CLEAR) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_addr_q;
      cnt_wdata = '0;
    end else begin
      cnt_we    = in_acc && (in_data_i.func == clr_pkg::FUNC_SET_COUNT) && dst_ok_in;
      cnt_waddr = in_data_i.dst_index[DST_AW-1:0];
      cnt_wdata = cnt_sat;
    end
    cnt_re = in_acc && (in_data_i.func == clr_pkg::FUNC_COMPUTE);

    line_we    = in_acc && (in_data_i.func == clr_pkg::FUNC_WRITE_SAMPLE) && src_ok_in;
    tap_src    = tap_rdata[TAP_DW-1 -: clr_pkg::SRC_W];
    line_re    = s1_q;
    line_raddr = tap_src[LINE_AW-1:0];

    mac_ctl.acc_clear = cnt_re;
    mac_ctl.mul_en    = s2_q;
    mac_ctl.round_en  = (state_q == ST_ROUND);
    // A tap whose source lies past the line contributes nothing.
    mac_sample = src_ok_q ? signed'(line_rdata) : 16'sd0;

    out_free = !out_valid_q || !out_stall_i;
    cfg_wr   = psel && penable && pwrite;
  end

  clr_ram #(
    .DEPTH (TAP_DEPTH),
    .WIDTH (TAP_DW),
    .AW    (TAP_AW)
  ) u_tap_ram (
    .clk_i   (clk_i),
    .we_i    (tap_we),
    .waddr_i (tap_waddr),
    .wdata_i ({in_data_i.src_index, in_data_i.weight}),
    .re_i    (tap_re),
    .raddr_i (tap_addr_q),
    .rdata_o (tap_rdata)
  );

  clr_ram #(
    .DEPTH (DST_EFF),
    .WIDTH (CNT_W),
    .AW    (DST_AW)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (cnt_re),
    .raddr_i (in_data_i.dst_index[DST_AW-1:0]),
    .rdata_o (cnt_rdata)
  );

  clr_ram #(
    .DEPTH (LINE_EFF),
    .WIDTH (clr_pkg::SAMPLE_W),
    .AW    (LINE_AW)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (in_data_i.src_index[LINE_AW-1:0]),
    .wdata_i (in_data_i.sample),
    .re_i    (line_re),
    .raddr_i (line_raddr),
    .rdata_o (line_rdata)
  );

  clr_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (mac_ctl),
    .sample_i      (mac_sample),
    .weight_i      (weight_q),
    .clamp_low_i   (clamp_low_q),
    .clamp_high_i  (clamp_high_q),
    .busy_o        (mac_busy),
    .pixel_value_o (mac_value),
    .saturated_o   (mac_sat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_addr_q   <= '0;
      issue_left_q <= '0;
      s1_q         <= 1'b0;
      s2_q         <= 1'b0;
      out_valid_q  <= 1'b0;
      clamp_low_q  <= '0;
      clamp_high_q <= '0;
    end else begin
      s1_q <= tap_re;
      s2_q <= s1_q;
      // The output register reloads in the same cycle its transfer completes.
      if ((state_q == ST_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_wr) begin
        if (paddr[2]) begin
          clamp_high_q <= signed'(pwdata[15:0]);
        end else begin
          clamp_low_q <= signed'(pwdata[15:0]);
        end
      end
      case (state_q)
        ST_CLEAR: begin
          clr_addr_q <= clr_addr_q + DST_AW'(1);
          if (clr_addr_q == DST_AW'(DST_EFF - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cnt_re) begin
            state_q <= ST_COUNT;
          end
        end
        ST_COUNT: begin
          issue_left_q <= dst_ok_q ? cnt_rdata : '0;
          state_q      <= ST_TAPS;
        end
        ST_TAPS: begin
          if (tap_re) begin
            issue_left_q <= issue_left_q - CNT_W'(1);
          end else if (!s1_q && !s2_q && !mac_busy) begin
            state_q <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cnt_re) begin
      dst_q      <= in_data_i.dst_index;
      dst_ok_q   <= dst_ok_in;
      tap_addr_q <= tap_base;
    end else if (tap_re) begin
      tap_addr_q <= tap_addr_q + TAP_AW'(1);
    end
    if (s1_q) begin
      weight_q <= signed'(tap_rdata[clr_pkg::WEIGHT_W-1:0]);
      src_ok_q <= {1'b0, tap_src} < 13'(LINE_EFF);
    end
    if ((state_q == ST_OUT) && out_free) begin
      out_data_q.pixel_index <= dst_q;
      out_data_q.pixel_value <= mac_value;
      out_data_q.saturated   <= mac_sat;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign pready      = 1'b1;
  assign prdata      = paddr[2] ? {{16{clamp_high_q[15]}}, clamp_high_q}
                                : {{16{clamp_low_q[15]}}, clamp_low_q};

endmodule
